### design/sed_pkg.sv
// ----------------------------------------------------------------------------
// Squeak event detector package
// Shared widths, register codes, configuration and word types, and a saturating-increment helper.
// ----------------------------------------------------------------------------
package sed_pkg;

    localparam int SEQ_W      = 32;
    localparam int RMS_W      = 16;
    localparam int BRIGHT_W   = 15;
    localparam int NOTE_W     = 7;
    localparam int RATIO_W    = 12;
    localparam int JUMP_W     = 6;
    localparam int COUNT_W    = 8;
    localparam int MINHIST_W  = 4;
    localparam int PROD_W     = BRIGHT_W + RATIO_W;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam int DEFAULT_HISTORY_DEPTH = 8;
    localparam int QUEUE_DEPTH           = 2;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 8'd255;

    localparam logic [RMS_W-1:0]     RST_SILENCE_LEVEL = 16'd328;
    localparam logic [RATIO_W-1:0]   RST_BURST_RATIO   = 12'd384;
    localparam logic [JUMP_W-1:0]    RST_MIN_JUMP      = 6'd5;
    localparam logic [COUNT_W-1:0]   RST_MAX_BURST     = 8'd3;
    localparam logic [MINHIST_W-1:0] RST_MIN_HISTORY   = 4'd4;
    localparam logic [COUNT_W-1:0]   RST_RETURN_WINDOW = 8'd4;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SILENCE_LEVEL  = 3'd0,
        CFG_BURST_RATIO    = 3'd1,
        CFG_MIN_JUMP       = 3'd2,
        CFG_MAX_BURST      = 3'd3,
        CFG_MIN_HISTORY    = 3'd4,
        CFG_RETURN_WINDOW  = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic [RMS_W-1:0]     silence_level;
        logic [RATIO_W-1:0]   burst_ratio;
        logic [JUMP_W-1:0]    min_semitone_jump;
        logic [COUNT_W-1:0]   max_burst_frames;
        logic [MINHIST_W-1:0] min_history_frames;
        logic [COUNT_W-1:0]   return_window;
    } t_cfg;

    // One classified frame as it travels from the front end to the back end.
    typedef struct packed {
        logic                gap;
        logic                silent;
        logic [BRIGHT_W-1:0] bright;
        logic                pitch_ok;
        logic [NOTE_W-1:0]   pitch_note;
        logic [NOTE_W-1:0]   expected_note;
    } t_item;

    typedef struct packed {
        logic                history_gap;
        logic                verdict_valid;
        logic [BRIGHT_W-1:0] brightness_used;
        logic [NOTE_W-1:0]   target_note;
        logic [BRIGHT_W-1:0] reference_hz;
        logic                is_candidate;
        logic                too_long;
        logic                is_confirmed;
        logic [COUNT_W-1:0]  burst_length;
    } t_result;

    function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
        logic [COUNT_W-1:0] r;
        r = (v == COUNT_MAX) ? v : v + 1'b1;
        return r;
    endfunction

endpackage

### design/sed_in_if.sv
// ----------------------------------------------------------------------------
// Frame feature channel
// Valid/ready channel carrying one frame's features per word.
// ----------------------------------------------------------------------------
interface sed_in_if import sed_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [SEQ_W-1:0]    frame_seq;
    logic                sound_detected;
    logic [RMS_W-1:0]    rms;
    logic [BRIGHT_W-1:0] pcm_brightness_hz;
    logic [BRIGHT_W-1:0] centroid_hz;
    logic                fft_fresh;
    logic                pitch_usable;
    logic [NOTE_W-1:0]   pitch_note;
    logic [NOTE_W-1:0]   expected_note;

    modport source (
        output valid, frame_seq, sound_detected, rms, pcm_brightness_hz,
               centroid_hz, fft_fresh, pitch_usable, pitch_note, expected_note,
        input  ready
    );
    modport sink (
        input  valid, frame_seq, sound_detected, rms, pcm_brightness_hz,
               centroid_hz, fft_fresh, pitch_usable, pitch_note, expected_note,
        output ready
    );
endinterface

### design/sed_out_if.sv
// ----------------------------------------------------------------------------
// Detector result channel
// Valid/ready channel carrying one judgement word per frame.
// ----------------------------------------------------------------------------
interface sed_out_if import sed_pkg::*; ();
    logic                valid;
    logic                ready;
    logic                history_gap;
    logic                verdict_valid;
    logic [BRIGHT_W-1:0] brightness_used;
    logic [NOTE_W-1:0]   target_note;
    logic [BRIGHT_W-1:0] reference_hz;
    logic                is_candidate;
    logic                too_long;
    logic                is_confirmed;
    logic [COUNT_W-1:0]  burst_length;

    modport source (
        output valid, history_gap, verdict_valid, brightness_used, target_note,
               reference_hz, is_candidate, too_long, is_confirmed, burst_length,
        input  ready
    );
    modport sink (
        input  valid, history_gap, verdict_valid, brightness_used, target_note,
               reference_hz, is_candidate, too_long, is_confirmed, burst_length,
        output ready
    );
endinterface

### design/sed_front.sv
// ----------------------------------------------------------------------------
// Squeak detector front end
// Accepts frame words, tracks the sequence number and classifies each frame.
// ----------------------------------------------------------------------------
module sed_front import sed_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sed_in_if.sink      i_frm,
    input  t_cfg        i_cfg,
    input  logic        i_q_full,
    output logic        o_push,
    output t_item       o_item
);

    logic             r_seen;
    logic [SEQ_W-1:0] r_prior_seq;
    logic             w_accept;
    logic [SEQ_W-1:0] w_next_seq;

    assign i_frm.ready = !i_q_full;
    assign w_accept    = i_frm.valid && !i_q_full;
    assign w_next_seq  = r_prior_seq + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen      <= 1'b0;
            r_prior_seq <= '0;
        end else if (w_accept) begin
            r_seen      <= 1'b1;
            r_prior_seq <= i_frm.frame_seq;
        end
    end

    always_comb begin
        o_item.gap    = r_seen && (i_frm.frame_seq != w_next_seq);
        o_item.silent = !i_frm.sound_detected || (i_frm.rms <= i_cfg.silence_level);
        // PCM brightness wins; a fresh centroid stands in when it is missing.
        if (i_frm.pcm_brightness_hz == '0 && i_frm.fft_fresh) begin
            o_item.bright = i_frm.centroid_hz;
        end else begin
            o_item.bright = i_frm.pcm_brightness_hz;
        end
        o_item.pitch_ok      = i_frm.pitch_usable && (i_frm.pitch_note != '0);
        o_item.pitch_note    = i_frm.pitch_note;
        o_item.expected_note = i_frm.expected_note;
    end

    assign o_push = w_accept;

endmodule

### design/sed_queue.sv
// ----------------------------------------------------------------------------
// Squeak detector item queue
// Short FIFO of classified frames between the front end and the back end.
// ----------------------------------------------------------------------------
module sed_queue import sed_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    input  logic  i_pop,
    output logic  o_full,
    output logic  o_empty,
    output t_item o_head
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_item            r_slot [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             w_do_push;
    logic             w_do_pop;

    assign o_full    = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_empty   = (r_count == '0);
    assign o_head    = r_slot[r_rd_ptr];
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_slot[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_do_push && !w_do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_do_pop && !w_do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

### design/sed_back.sv
// ----------------------------------------------------------------------------
// Squeak detector back end
// Sequencer that keeps the brightness ring, averages it with a serial
// divider, judges bursts and holds the result word for the output channel.
// ----------------------------------------------------------------------------
module sed_back import sed_pkg::*; #(
    parameter int HISTORY_DEPTH = DEFAULT_HISTORY_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  logic        i_q_empty,
    input  t_item       i_q_head,
    output logic        o_q_pop,
    sed_out_if.source   o_res
);

    localparam int HEAD_W = $clog2(HISTORY_DEPTH);
    localparam int FILL_W = $clog2(HISTORY_DEPTH + 1);
    localparam int SUM_W  = BRIGHT_W + FILL_W;
    localparam int DCNT_W = $clog2(SUM_W + 1);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_CHECK  = 7'b0000010,
        S_SUM    = 7'b0000100,
        S_DIV    = 7'b0001000,
        S_MUL    = 7'b0010000,
        S_DECIDE = 7'b0100000,
        S_EMIT   = 7'b1000000
    } t_state;

    t_state r_state, n_state;
    t_item  r_item, n_item;
    t_result r_res, n_res;
    t_result r_out;
    logic    r_out_vld, n_out_vld;

    // Ring of recent brightness values, read one entry a cycle while summing.
    logic [BRIGHT_W-1:0] r_mem [HISTORY_DEPTH];
    logic [BRIGHT_W-1:0] r_rdata;
    logic                r_rd_pend;
    logic                w_rd_en;
    logic                w_wr_en;

    logic [HEAD_W-1:0]  r_head, n_head;
    logic [FILL_W-1:0]  r_fill, n_fill;
    logic [COUNT_W-1:0] r_cnt, n_cnt;
    logic [COUNT_W-1:0] r_saved, n_saved;
    logic [COUNT_W-1:0] r_since, n_since;
    logic               r_wait, n_wait;
    logic [BRIGHT_W-1:0] r_frozen, n_frozen;
    logic [NOTE_W-1:0]  r_held, n_held;

    logic [NOTE_W-1:0]   r_target, n_target;
    logic [BRIGHT_W-1:0] r_ref, n_ref;
    logic [FILL_W-1:0]   r_idx, n_idx;
    logic [SUM_W-1:0]    r_sum, n_sum;
    logic [SUM_W-1:0]    r_quo, n_quo;
    logic [FILL_W-1:0]   r_rem, n_rem;
    logic [DCNT_W-1:0]   r_dcnt, n_dcnt;
    logic [PROD_W-1:0]   r_prod, n_prod;

    logic [NOTE_W-1:0]   w_target;
    logic [FILL_W+1:0]   w_trial;
    logic [FILL_W:0]     w_shift;
    logic                w_burst;
    logic                w_wrong;
    logic signed [NOTE_W:0] w_diff;
    logic                w_out_free;
    logic                v_wait;
    logic [COUNT_W-1:0]  v_since;
    logic [COUNT_W-1:0]  v_saved;
    logic [COUNT_W-1:0]  v_cnt;

    assign w_target   = (r_item.expected_note != '0) ? r_item.expected_note : r_held;
    assign w_shift    = {r_rem, r_quo[SUM_W-1]};
    assign w_trial    = {1'b0, w_shift} - {2'b00, r_fill};
    assign w_diff     = $signed({1'b0, r_item.pitch_note}) - $signed({1'b0, r_target});
    assign w_burst    = (r_ref != '0) && (PROD_W'({r_item.bright, 8'h00}) >= r_prod);
    assign w_wrong    = !r_item.pitch_ok ||
                        (w_diff >= $signed({2'b00, i_cfg.min_semitone_jump}));
    assign w_out_free = !r_out_vld || o_res.ready;
    assign w_rd_en    = (r_state == S_SUM) && (r_idx != r_fill);

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[r_head] <= r_item.bright;
        end
        if (w_rd_en) begin
            r_rdata <= r_mem[r_idx[HEAD_W-1:0]];
        end
    end

    always_comb begin
        n_state   = r_state;
        n_item    = r_item;
        n_res     = r_res;
        n_out_vld = r_out_vld && !o_res.ready;
        n_head    = r_head;
        n_fill    = r_fill;
        n_cnt     = r_cnt;
        n_saved   = r_saved;
        n_since   = r_since;
        n_wait    = r_wait;
        n_frozen  = r_frozen;
        n_held    = r_held;
        n_target  = r_target;
        n_ref     = r_ref;
        n_idx     = r_idx;
        n_sum     = r_sum;
        n_quo     = r_quo;
        n_rem     = r_rem;
        n_dcnt    = r_dcnt;
        n_prod    = r_prod;
        o_q_pop   = 1'b0;
        w_wr_en   = 1'b0;
        v_wait    = r_wait;
        v_since   = r_since;
        v_saved   = r_saved;
        v_cnt     = r_cnt;

        case (r_state)
            S_IDLE: begin
                if (!i_q_empty) begin
                    o_q_pop = 1'b1;
                    n_item  = i_q_head;
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                n_res = '0;
                if (r_item.gap || r_item.silent) begin
                    n_res.history_gap = r_item.gap;
                    n_head   = '0;
                    n_fill   = '0;
                    n_cnt    = '0;
                    n_saved  = '0;
                    n_since  = '0;
                    n_wait   = 1'b0;
                    n_frozen = '0;
                    n_held   = '0;
                    n_state  = S_EMIT;
                end else if (r_item.bright == '0) begin
                    n_state = S_EMIT;
                end else if (w_target == '0 ||
                             (8'(r_fill) < 8'(i_cfg.min_history_frames) && r_cnt == '0)) begin
                    // Not enough to judge yet: learn the note and grow the baseline.
                    n_res.brightness_used = r_item.bright;
                    n_res.target_note     = w_target;
                    if (r_item.pitch_ok) begin
                        n_held = r_item.pitch_note;
                    end
                    w_wr_en = 1'b1;
                    n_head  = (r_head == HEAD_W'(HISTORY_DEPTH - 1)) ? '0 : r_head + 1'b1;
                    n_fill  = (r_fill == FILL_W'(HISTORY_DEPTH)) ? r_fill : r_fill + 1'b1;
                    n_state = S_EMIT;
                end else begin
                    n_target = w_target;
                    n_idx    = '0;
                    n_sum    = '0;
                    if (r_cnt != '0) begin
                        n_ref   = r_frozen;
                        n_state = S_MUL;
                    end else if (r_fill == '0) begin
                        n_ref   = '0;
                        n_state = S_MUL;
                    end else begin
                        n_state = S_SUM;
                    end
                end
            end
            S_SUM: begin
                if (w_rd_en) begin
                    n_idx = r_idx + 1'b1;
                end
                if (r_rd_pend) begin
                    n_sum = r_sum + SUM_W'(r_rdata);
                end
                if (!w_rd_en && !r_rd_pend) begin
                    n_quo   = r_sum;
                    n_rem   = '0;
                    n_dcnt  = DCNT_W'(SUM_W);
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                // Restoring division of the ring sum by the fill count, one bit a cycle.
                if (r_dcnt == '0) begin
                    n_ref   = r_quo[BRIGHT_W-1:0];
                    n_state = S_MUL;
                end else begin
                    n_dcnt = r_dcnt - 1'b1;
                    if (!w_trial[FILL_W+1]) begin
                        n_rem = w_trial[FILL_W-1:0];
                        n_quo = {r_quo[SUM_W-2:0], 1'b1};
                    end else begin
                        n_rem = w_shift[FILL_W-1:0];
                        n_quo = {r_quo[SUM_W-2:0], 1'b0};
                    end
                end
            end
            S_MUL: begin
                n_prod  = PROD_W'(r_ref) * PROD_W'(i_cfg.burst_ratio);
                n_state = S_DECIDE;
            end
            S_DECIDE: begin
                n_res.verdict_valid   = 1'b1;
                n_res.brightness_used = r_item.bright;
                n_res.target_note     = r_target;
                n_res.reference_hz    = r_ref;
                if (w_burst && w_wrong) begin
                    // The baseline is frozen on the first frame of a burst.
                    if (r_cnt == '0) begin
                        n_frozen = r_ref;
                    end
                    v_cnt  = sat_inc(r_cnt);
                    n_cnt  = v_cnt;
                    n_wait = 1'b0;
                    n_res.burst_length = v_cnt;
                    if (v_cnt <= i_cfg.max_burst_frames) begin
                        n_res.is_candidate = 1'b1;
                    end else begin
                        n_res.too_long = 1'b1;
                    end
                end else begin
                    if (r_cnt != '0) begin
                        if (r_cnt <= i_cfg.max_burst_frames) begin
                            v_wait  = 1'b1;
                            v_saved = r_cnt;
                            v_since = '0;
                        end
                        n_cnt = '0;
                    end
                    w_wr_en = 1'b1;
                    n_head  = (r_head == HEAD_W'(HISTORY_DEPTH - 1)) ? '0 : r_head + 1'b1;
                    n_fill  = (r_fill == FILL_W'(HISTORY_DEPTH)) ? r_fill : r_fill + 1'b1;
                    if (r_item.pitch_ok) begin
                        n_held = r_item.pitch_note;
                    end
                    if (v_wait) begin
                        v_since = sat_inc(v_since);
                        if (r_item.pitch_ok && r_item.pitch_note == r_target) begin
                            n_res.is_confirmed = 1'b1;
                            n_res.burst_length = v_saved;
                            v_wait = 1'b0;
                        end else if (v_since >= i_cfg.return_window) begin
                            v_wait = 1'b0;
                        end
                    end
                    n_wait  = v_wait;
                    n_since = v_since;
                    n_saved = v_saved;
                end
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (w_out_free) begin
                    n_out_vld = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_out_vld <= 1'b0;
            r_rd_pend <= 1'b0;
            r_head    <= '0;
            r_fill    <= '0;
            r_cnt     <= '0;
            r_saved   <= '0;
            r_since   <= '0;
            r_wait    <= 1'b0;
            r_frozen  <= '0;
            r_held    <= '0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
            r_rd_pend <= w_rd_en;
            r_head    <= n_head;
            r_fill    <= n_fill;
            r_cnt     <= n_cnt;
            r_saved   <= n_saved;
            r_since   <= n_since;
            r_wait    <= n_wait;
            r_frozen  <= n_frozen;
            r_held    <= n_held;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item   <= n_item;
        r_res    <= n_res;
        r_target <= n_target;
        r_ref    <= n_ref;
        r_idx    <= n_idx;
        r_sum    <= n_sum;
        r_quo    <= n_quo;
        r_rem    <= n_rem;
        r_dcnt   <= n_dcnt;
        r_prod   <= n_prod;
        if (r_state == S_EMIT && w_out_free) begin
            r_out <= r_res;
        end
    end

    assign o_res.valid           = r_out_vld;
    assign o_res.history_gap     = r_out.history_gap;
    assign o_res.verdict_valid   = r_out.verdict_valid;
    assign o_res.brightness_used = r_out.brightness_used;
    assign o_res.target_note     = r_out.target_note;
    assign o_res.reference_hz    = r_out.reference_hz;
    assign o_res.is_candidate    = r_out.is_candidate;
    assign o_res.too_long        = r_out.too_long;
    assign o_res.is_confirmed    = r_out.is_confirmed;
    assign o_res.burst_length    = r_out.burst_length;

endmodule

### design/squeak_event_detector.sv
// ----------------------------------------------------------------------------
// Squeak event detector
// Top level: configuration registers, front end, item queue and back end.
// ----------------------------------------------------------------------------
// Each frame word gives exactly one result word, in order. The front end takes
// a frame in the cycle it is offered as long as the two-entry queue has room,
// so up to two queued frames, the frame being judged and the word in the
// output register can be in flight.
// The back end works on one frame at a time: a gap, silent, dark or
// still-learning frame goes from the check state straight to emit; a frame
// inside a burst goes through check, multiply, decide and emit; any other
// judged frame first reads its fill ring entries (at most HISTORY_DEPTH) one
// per cycle from the ring memory and sums them, then runs the SUM_W = 15 +
// clog2(HISTORY_DEPTH + 1) steps of the serial divider that form the baseline mean.
// Registers are written through i_cfg_we/i_cfg_idx/i_cfg_data and must only
// change while no frame is in flight.
module squeak_event_detector import sed_pkg::*; #(
    parameter int HISTORY_DEPTH = DEFAULT_HISTORY_DEPTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    sed_in_if.sink                i_frame,
    sed_out_if.source             o_result,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg  r_cfg;
    logic  w_push;
    logic  w_pop;
    logic  w_full;
    logic  w_empty;
    t_item w_item;
    t_item w_head;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.silence_level      <= RST_SILENCE_LEVEL;
            r_cfg.burst_ratio        <= RST_BURST_RATIO;
            r_cfg.min_semitone_jump  <= RST_MIN_JUMP;
            r_cfg.max_burst_frames   <= RST_MAX_BURST;
            r_cfg.min_history_frames <= RST_MIN_HISTORY;
            r_cfg.return_window      <= RST_RETURN_WINDOW;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_SILENCE_LEVEL: r_cfg.silence_level      <= i_cfg_data;
                CFG_BURST_RATIO:   r_cfg.burst_ratio        <= i_cfg_data[RATIO_W-1:0];
                CFG_MIN_JUMP:      r_cfg.min_semitone_jump  <= i_cfg_data[JUMP_W-1:0];
                CFG_MAX_BURST:     r_cfg.max_burst_frames   <= i_cfg_data[COUNT_W-1:0];
                CFG_MIN_HISTORY:   r_cfg.min_history_frames <= i_cfg_data[MINHIST_W-1:0];
                CFG_RETURN_WINDOW: r_cfg.return_window      <= i_cfg_data[COUNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    sed_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_frm    (i_frame),
        .i_cfg    (r_cfg),
        .i_q_full (w_full),
        .o_push   (w_push),
        .o_item   (w_item)
    );

    sed_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_item),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_empty (w_empty),
        .o_head  (w_head)
    );

    sed_back #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_q_empty (w_empty),
        .i_q_head  (w_head),
        .o_q_pop   (w_pop),
        .o_res     (o_result)
    );

    // A sequence-gap word carries nothing but the gap flag.
    a_gap_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && o_result.history_gap) |->
            (!o_result.verdict_valid && o_result.brightness_used == '0))
        else $error("gap word carries other fields");

    // Candidate, too long and confirmed are mutually exclusive verdicts.
    a_one_verdict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid |->
            $countones({o_result.is_candidate, o_result.too_long,
                        o_result.is_confirmed}) <= 1)
        else $error("more than one verdict in a word");

    // Any verdict flag needs a judged frame with a nonzero burst length.
    a_verdict_judged: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && (o_result.is_candidate || o_result.too_long ||
                            o_result.is_confirmed)) |->
            (o_result.verdict_valid && o_result.burst_length != '0))
        else $error("verdict without judgement");

    // The queue never accepts a word while it already holds two.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_full |-> !i_frame.ready)
        else $error("frame accepted into a full queue");

endmodule

### tb/sv/tb_squeak_event_detector.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Squeak event detector testbench
// Streams frame feature words through the detector under several register
// settings, predicts every judgement word in the bench and compares each
// returned word field by field, with random source gaps and sink stalls.
// ----------------------------------------------------------------------------
module tb_squeak_event_detector;
    import sed_pkg::*;

    localparam int          RING_DEPTH   = DEFAULT_HISTORY_DEPTH;
    localparam int          SETTLE_CYCLES = 48;
    localparam int          LONG_HOLD    = 400;
    localparam int unsigned CYCLE_LIMIT  = 800000;

    typedef struct {
        logic [SEQ_W-1:0]    frame_seq;
        logic                sound_detected;
        logic [RMS_W-1:0]    rms;
        logic [BRIGHT_W-1:0] pcm_hz;
        logic [BRIGHT_W-1:0] centroid_hz;
        logic                fft_fresh;
        logic                pitch_usable;
        logic [NOTE_W-1:0]   pitch_note;
        logic [NOTE_W-1:0]   expected_note;
        bit                  drain_first;
    } frame_word_t;

    typedef enum int {
        RX_OPEN,
        RX_LIGHT,
        RX_HEAVY
    } rx_mode_t;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    sed_in_if  frm ();
    sed_out_if res ();

    squeak_event_detector dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_frame    (frm),
        .o_result   (res),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    frame_word_t frame_q[$];
    t_result     predicted_q[$];
    frame_word_t offered;
    bit          frame_taken;

    // Register copy and detector state as the bench predicts them.
    t_cfg                cfg_shadow;
    bit                  seq_known;
    logic [SEQ_W-1:0]    last_seq;
    logic [BRIGHT_W-1:0] bright_ring [RING_DEPTH];
    int unsigned         ring_wr, ring_cnt;
    int unsigned         burst_run, saved_run, since_burst;
    bit                  awaiting_return;
    int unsigned         frozen_base, note_held;

    // Generator and handshake pacing.
    logic [SEQ_W-1:0] gen_seq;
    int unsigned      gen_count;
    bit               next_hold, long_burst_req, long_hold_req;
    int unsigned      burst_left, gap_left, hold_left, mode_left;
    rx_mode_t         rx_mode;

    int unsigned err_count, cycle_count, settings_used;
    int unsigned frames_accepted, words_checked;
    int unsigned cand_seen, long_seen, confirm_seen, gap_seen;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------
    function automatic void forget_tracking();
        ring_wr = 0;
        ring_cnt = 0;
        burst_run = 0;
        saved_run = 0;
        since_burst = 0;
        awaiting_return = 1'b0;
        frozen_base = 0;
        note_held = 0;
    endfunction

    function automatic void push_brightness(input int unsigned v);
        bright_ring[ring_wr] = v[BRIGHT_W-1:0];
        ring_wr = (ring_wr + 1) % RING_DEPTH;
        if (ring_cnt < RING_DEPTH) ring_cnt++;
    endfunction

    // Only the filled slots are averaged; they always start at slot zero.
    function automatic int unsigned baseline_mean();
        int unsigned sum;
        sum = 0;
        if (ring_cnt == 0) return 0;
        for (int i = 0; i < ring_cnt; i++) sum += bright_ring[i];
        return sum / ring_cnt;
    endfunction

    function automatic t_result predict_verdict(input frame_word_t f);
        t_result     r;
        int unsigned bright, target, base, note;
        bit          pitch_ok, wrong, burst;
        r = '0;
        if (seq_known && f.frame_seq != last_seq + 32'd1) begin
            forget_tracking();
            last_seq = f.frame_seq;
            r.history_gap = 1'b1;
            return r;
        end
        seq_known = 1'b1;
        last_seq = f.frame_seq;
        if (!f.sound_detected || f.rms <= cfg_shadow.silence_level) begin
            forget_tracking();
            return r;
        end
        bright = f.pcm_hz;
        if (bright == 0 && f.fft_fresh && f.centroid_hz != 0) bright = f.centroid_hz;
        r.brightness_used = bright[BRIGHT_W-1:0];
        if (bright == 0) return r;

        note = f.pitch_note;
        pitch_ok = f.pitch_usable && note != 0;
        target = (f.expected_note != 0) ? f.expected_note : note_held;
        r.target_note = target[NOTE_W-1:0];
        if (target == 0 || (ring_cnt < cfg_shadow.min_history_frames && burst_run == 0)) begin
            if (pitch_ok) note_held = note;
            push_brightness(bright);
            return r;
        end

        r.verdict_valid = 1'b1;
        base = (burst_run > 0) ? frozen_base : baseline_mean();
        r.reference_hz = base[BRIGHT_W-1:0];
        burst = base != 0 && bright * 256 >= base * cfg_shadow.burst_ratio;
        if (pitch_ok)
            wrong = (int'(note) - int'(target)) >= int'(cfg_shadow.min_semitone_jump);
        else
            wrong = 1'b1;

        if (burst && wrong) begin
            if (burst_run == 0) frozen_base = baseline_mean();
            if (burst_run < COUNT_MAX) burst_run++;
            awaiting_return = 1'b0;
            r.burst_length = burst_run[COUNT_W-1:0];
            if (burst_run <= cfg_shadow.max_burst_frames) r.is_candidate = 1'b1;
            else r.too_long = 1'b1;
            return r;
        end

        // A burst that stayed short enough opens the window for the return.
        if (burst_run > 0) begin
            if (burst_run <= cfg_shadow.max_burst_frames) begin
                awaiting_return = 1'b1;
                saved_run = burst_run;
                since_burst = 0;
            end
            burst_run = 0;
        end
        push_brightness(bright);
        if (pitch_ok) note_held = note;

        if (awaiting_return) begin
            if (since_burst < COUNT_MAX) since_burst++;
            if (pitch_ok && note == target) begin
                r.is_confirmed = 1'b1;
                r.burst_length = saved_run[COUNT_W-1:0];
                awaiting_return = 1'b0;
            end else if (since_burst >= cfg_shadow.return_window) begin
                awaiting_return = 1'b0;
            end
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Frame generation
    // ------------------------------------------------------------------
    task automatic queue_frame(input bit snd, input int unsigned lvl, input int unsigned pcm,
                               input int unsigned cen, input bit fresh, input bit usable,
                               input int unsigned note, input int unsigned want_note);
        frame_word_t w;
        w.frame_seq      = gen_seq;
        w.sound_detected = snd;
        w.rms            = lvl[RMS_W-1:0];
        w.pcm_hz         = pcm[BRIGHT_W-1:0];
        w.centroid_hz    = cen[BRIGHT_W-1:0];
        w.fft_fresh      = fresh;
        w.pitch_usable   = usable;
        w.pitch_note     = note[NOTE_W-1:0];
        w.expected_note  = want_note[NOTE_W-1:0];
        w.drain_first    = next_hold;
        next_hold = 1'b0;
        gen_seq = gen_seq + 32'd1;
        gen_count++;
        frame_q.push_back(w);
    endtask

    task automatic queue_tone(input int unsigned pcm, input int unsigned note,
                              input int unsigned want_note);
        queue_frame(1'b1, 20000, pcm, 0, 1'b0, 1'b1, note, want_note);
    endtask

    task automatic queue_noise_frame();
        queue_frame($urandom_range(1, 0), $urandom_range(65535, 0), $urandom_range(32767, 0),
                    $urandom_range(32767, 0), $urandom_range(1, 0), $urandom_range(1, 0),
                    $urandom_range(127, 0),
                    ($urandom_range(2, 0) == 0) ? 0 : $urandom_range(127, 0));
    endtask

    function automatic int unsigned loud_rms();
        int unsigned quiet;
        quiet = cfg_shadow.silence_level;
        if (quiet >= 65535) return $urandom_range(65535, 0);
        return $urandom_range(65535, quiet + 1);
    endfunction

    // A note close enough to the target that it never counts as wrong.
    function automatic int unsigned calm_note(input int unsigned target, input int unsigned jump);
        int unsigned lo, hi;
        lo = (target > 2) ? target - 2 : 1;
        hi = (target + jump - 1 > 127) ? 127 : target + jump - 1;
        return $urandom_range(hi, lo);
    endfunction

    // Settle on a note, burst bright and off pitch, then drift and return.
    task automatic queue_phrase();
        int unsigned target, base, cap, jump, warm, blen, ret, n, want, top, loud, room;
        jump = cfg_shadow.min_semitone_jump;
        target = $urandom_range(127, 1);
        cap = 8388352 / cfg_shadow.burst_ratio * 3 / 4;
        base = $urandom_range(cap, 40);
        want = ($urandom_range(3, 0) != 0) ? target : 0;
        warm = cfg_shadow.min_history_frames + $urandom_range(4, 0);
        queue_frame(1'b1, loud_rms(), base, 0, 1'b0, 1'b1, target, want);
        for (int i = 1; i < warm; i++)
            queue_frame(1'b1, loud_rms(), base + $urandom_range(base / 8, 0), 0, 1'b0, 1'b1,
                        calm_note(target, jump), want);

        if (long_burst_req) begin
            blen = 258;
            long_burst_req = 1'b0;
        end else begin
            top = cfg_shadow.max_burst_frames + 2;
            if (top > 14) top = 14;
            blen = $urandom_range(top, 1);
        end
        loud = (base + base / 8) * cfg_shadow.burst_ratio / 256 + 1;
        for (int i = 0; i < blen; i++) begin
            n = loud + $urandom_range(base / 4, 0);
            if (n > 32767) n = 32767;
            if (target + jump <= 127 && $urandom_range(3, 0) != 0) begin
                room = 127 - target - jump;
                queue_frame(1'b1, loud_rms(), n, 0, 1'b0, 1'b1,
                            target + jump + $urandom_range((room < 10) ? room : 10, 0), want);
            end else begin
                queue_frame(1'b1, loud_rms(), n, $urandom_range(32767, 0), $urandom_range(1, 0),
                            1'b0, $urandom_range(127, 0), want);
            end
        end

        top = cfg_shadow.return_window + 1;
        if (top > 8) top = 8;
        ret = $urandom_range(top, 0);
        for (int i = 0; i < ret; i++)
            queue_frame(1'b1, loud_rms(), base - $urandom_range(base / 8, 0), 0, 1'b0, 1'b1,
                        (target > 3) ? target - 1 - $urandom_range(2, 0) : target + 1, want);
        if ($urandom_range(3, 0) != 0)
            queue_frame(1'b1, loud_rms(), base, 0, 1'b0, 1'b1, target, want);
        n = $urandom_range(3, 0);
        for (int i = 0; i < n; i++)
            queue_frame(1'b1, loud_rms(), base + $urandom_range(base / 8, 0), 0, 1'b0, 1'b1,
                        calm_note(target, jump), want);
    endtask

    task automatic gen_random(input int unsigned count);
        int unsigned stop_at, pick, n;
        logic [SEQ_W-1:0] fresh_seq;
        stop_at = gen_count + count;
        while (gen_count < stop_at) begin
            pick = $urandom_range(99, 0);
            if (pick < 60) begin
                if ($urandom_range(59, 0) == 0) next_hold = 1'b1;
                queue_phrase();
            end else if (pick < 70) begin
                n = $urandom_range(3, 1);
                for (int i = 0; i < n; i++) begin
                    if ($urandom_range(1, 0) != 0)
                        queue_frame(1'b1, $urandom_range(cfg_shadow.silence_level, 0),
                                    $urandom_range(32767, 1), 0, 1'b0, 1'b1,
                                    $urandom_range(127, 1), $urandom_range(127, 0));
                    else
                        queue_frame(1'b0, $urandom_range(65535, 0), $urandom_range(32767, 0),
                                    $urandom_range(32767, 0), $urandom_range(1, 0), 1'b1,
                                    $urandom_range(127, 0), $urandom_range(127, 0));
                end
            end else if (pick < 76) begin
                if ($urandom_range(1, 0) != 0)
                    queue_frame(1'b1, loud_rms(), 0, $urandom_range(32767, 1), 1'b0, 1'b1,
                                $urandom_range(127, 1), $urandom_range(127, 1));
                else
                    queue_frame(1'b1, loud_rms(), 0, 0, 1'b1, 1'b1,
                                $urandom_range(127, 1), $urandom_range(127, 1));
            end else if (pick < 82) begin
                fresh_seq = $urandom;
                if (fresh_seq == gen_seq) fresh_seq = fresh_seq + 32'd7;
                gen_seq = fresh_seq;
                queue_noise_frame();
            end else begin
                queue_noise_frame();
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Register writes and idle detection
    // ------------------------------------------------------------------
    task automatic write_reg(input t_cfg_idx idx, input int unsigned val);
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = val[CFG_DATA_W-1:0];
        @(negedge i_clk);
        i_cfg_we   = 1'b0;
        case (idx)
            CFG_SILENCE_LEVEL: cfg_shadow.silence_level      = val[RMS_W-1:0];
            CFG_BURST_RATIO:   cfg_shadow.burst_ratio        = val[RATIO_W-1:0];
            CFG_MIN_JUMP:      cfg_shadow.min_semitone_jump  = val[JUMP_W-1:0];
            CFG_MAX_BURST:     cfg_shadow.max_burst_frames   = val[COUNT_W-1:0];
            CFG_MIN_HISTORY:   cfg_shadow.min_history_frames = val[MINHIST_W-1:0];
            CFG_RETURN_WINDOW: cfg_shadow.return_window      = val[COUNT_W-1:0];
            default: ;
        endcase
    endtask

    task automatic apply_settings(input int unsigned quiet, input int unsigned ratio,
                                  input int unsigned jump, input int unsigned max_run,
                                  input int unsigned min_hist, input int unsigned window);
        write_reg(CFG_SILENCE_LEVEL, quiet);
        write_reg(CFG_BURST_RATIO, ratio);
        write_reg(CFG_MIN_JUMP, jump);
        write_reg(CFG_MAX_BURST, max_run);
        write_reg(CFG_MIN_HISTORY, min_hist);
        write_reg(CFG_RETURN_WINDOW, window);
        settings_used++;
    endtask

    // Checked a little after the falling edge, once every update has landed.
    task automatic wait_idle();
        do begin
            @(negedge i_clk);
            #1;
        end while (frame_q.size() != 0 || frm.valid || predicted_q.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Source side: bursts of words separated by random gaps
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin : frame_driver
        bit was_taken;
        was_taken = frame_taken;
        frame_taken = 1'b0;
        if (!i_rst_n) begin
            frm.valid <= 1'b0;
        end else if (!frm.valid || was_taken) begin
            if (gap_left > 0) begin
                gap_left--;
                frm.valid <= 1'b0;
            end else if (frame_q.size() != 0 &&
                         !(frame_q[0].drain_first && predicted_q.size() != 0)) begin
                offered = frame_q.pop_front();
                frm.frame_seq         <= offered.frame_seq;
                frm.sound_detected    <= offered.sound_detected;
                frm.rms               <= offered.rms;
                frm.pcm_brightness_hz <= offered.pcm_hz;
                frm.centroid_hz       <= offered.centroid_hz;
                frm.fft_fresh         <= offered.fft_fresh;
                frm.pitch_usable      <= offered.pitch_usable;
                frm.pitch_note        <= offered.pitch_note;
                frm.expected_note     <= offered.expected_note;
                frm.valid             <= 1'b1;
                if (burst_left > 1) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(30, 1);
                    gap_left = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(8, 1);
                end
            end else begin
                frm.valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Sink side: stall pattern in stretches, plus one long hold-off
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin : result_receiver
        if (long_hold_req) begin
            hold_left = LONG_HOLD;
            long_hold_req = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            res.ready <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                rx_mode = rx_mode_t'($urandom_range(2, 0));
                mode_left = $urandom_range(150, 20);
            end
            mode_left--;
            case (rx_mode)
                RX_OPEN:  res.ready <= 1'b1;
                RX_LIGHT: res.ready <= ($urandom_range(3, 0) != 0);
                default:  res.ready <= ($urandom_range(9, 0) < 4);
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Prediction on acceptance, comparison on each returned word
    // ------------------------------------------------------------------
    task automatic check_field(input string name, input int unsigned want, input int unsigned got);
        if (want != got) begin
            err_count++;
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin : result_monitor
        t_result got, want;
        if (i_rst_n) begin
            if (frm.valid && frm.ready) begin
                predicted_q.push_back(predict_verdict(offered));
                frame_taken = 1'b1;
                frames_accepted++;
            end
            if (res.valid && res.ready) begin
                got.history_gap     = res.history_gap;
                got.verdict_valid   = res.verdict_valid;
                got.brightness_used = res.brightness_used;
                got.target_note     = res.target_note;
                got.reference_hz    = res.reference_hz;
                got.is_candidate    = res.is_candidate;
                got.too_long        = res.too_long;
                got.is_confirmed    = res.is_confirmed;
                got.burst_length    = res.burst_length;
                if (predicted_q.size() == 0) begin
                    err_count++;
                    $display("%0t ns: result word with no frame pending, expected none, actual %h",
                             $time, got);
                end else begin
                    want = predicted_q.pop_front();
                    words_checked++;
                    cand_seen    += want.is_candidate;
                    long_seen    += want.too_long;
                    confirm_seen += want.is_confirmed;
                    gap_seen     += want.history_gap;
                    check_field("history_gap", want.history_gap, got.history_gap);
                    check_field("verdict_valid", want.verdict_valid, got.verdict_valid);
                    check_field("brightness_used", want.brightness_used, got.brightness_used);
                    check_field("target_note", want.target_note, got.target_note);
                    check_field("reference_hz", want.reference_hz, got.reference_hz);
                    check_field("is_candidate", want.is_candidate, got.is_candidate);
                    check_field("too_long", want.too_long, got.too_long);
                    check_field("is_confirmed", want.is_confirmed, got.is_confirmed);
                    check_field("burst_length", want.burst_length, got.burst_length);
                end
            end
        end
    end

    always @(posedge i_clk) begin : watchdog
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d words outstanding",
                     cycle_count, predicted_q.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin : stimulus
        frm.valid             = 1'b0;
        frm.frame_seq         = '0;
        frm.sound_detected    = 1'b0;
        frm.rms               = '0;
        frm.pcm_brightness_hz = '0;
        frm.centroid_hz       = '0;
        frm.fft_fresh         = 1'b0;
        frm.pitch_usable      = 1'b0;
        frm.pitch_note        = '0;
        frm.expected_note     = '0;
        res.ready             = 1'b0;
        i_cfg_we              = 1'b0;
        i_cfg_idx             = CFG_SILENCE_LEVEL;
        i_cfg_data            = '0;
        i_rst_n               = 1'b0;

        cfg_shadow.silence_level      = RST_SILENCE_LEVEL;
        cfg_shadow.burst_ratio        = RST_BURST_RATIO;
        cfg_shadow.min_semitone_jump  = RST_MIN_JUMP;
        cfg_shadow.max_burst_frames   = RST_MAX_BURST;
        cfg_shadow.min_history_frames = RST_MIN_HISTORY;
        cfg_shadow.return_window      = RST_RETURN_WINDOW;
        seq_known = 1'b0;
        last_seq = '0;
        forget_tracking();
        burst_left = 1;
        settings_used = 1;

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed frames under the reset settings, starting just before the
        // sequence number wraps.
        gen_seq = 32'hFFFF_FFFE;
        queue_frame(1'b0, 20000, 1000, 0, 1'b0, 1'b1, 60, 60);      // sound flag off
        queue_frame(1'b1, 328, 1000, 0, 1'b0, 1'b1, 60, 60);        // level equal to silence
        queue_frame(1'b1, 329, 0, 1000, 1'b0, 1'b1, 60, 60);        // stale centroid, dark
        queue_frame(1'b1, 329, 0, 1000, 1'b1, 1'b1, 60, 0);         // fresh centroid, no target
        queue_frame(1'b1, 65535, 1000, 0, 1'b0, 1'b1, 0, 0);        // note zero is unusable
        queue_tone(1000, 60, 60);
        queue_tone(1000, 60, 60);
        queue_tone(1000, 60, 60);                                   // first verdict
        queue_tone(1600, 66, 60);                                   // burst starts
        queue_frame(1'b1, 20000, 2000, 0, 1'b0, 1'b0, 60, 60);      // unusable pitch in burst
        queue_tone(1000, 60, 60);                                   // confirmed return
        repeat (4) queue_tone(32767, 127, 60);                      // runs past the limit
        queue_tone(1000, 61, 60);
        queue_tone(32767, 127, 60);
        repeat (4) queue_tone(1000, 62, 60);                        // window runs out
        queue_tone(1000, 60, 60);
        gen_seq = 32'h0000_1234;
        queue_frame(1'b1, 65535, 32767, 32767, 1'b1, 1'b1, 127, 127); // sequence gap
        queue_frame(1'b1, 65535, 32767, 32767, 1'b1, 1'b1, 127, 127);
        queue_frame(1'b0, 0, 0, 0, 1'b0, 1'b0, 0, 0);

        gen_random(150);
        next_hold = 1'b1;
        gen_random(150);
        #1;
        long_hold_req = 1'b1;
        wait_idle();

        apply_settings(0, 256, 1, 1, 1, 1);
        gen_random(250);
        wait_idle();

        apply_settings(60000, 4095, 48, 254, 8, 255);
        long_burst_req = 1'b1;
        gen_random(350);
        wait_idle();

        apply_settings(65535, 384, 5, 3, 4, 4);
        gen_random(40);
        wait_idle();

        repeat (4) begin
            apply_settings($urandom_range(8000, 0), $urandom_range(4095, 256),
                           $urandom_range(48, 1),
                           ($urandom_range(1, 0) != 0) ? $urandom_range(8, 1)
                                                       : $urandom_range(254, 1),
                           $urandom_range(8, 1),
                           ($urandom_range(1, 0) != 0) ? $urandom_range(12, 1)
                                                       : $urandom_range(255, 1));
            gen_random(250);
            wait_idle();
        end

        if (predicted_q.size() != 0) begin
            err_count++;
            $display("%0t ns: %0d predicted words never arrived", $time, predicted_q.size());
        end
        $display("Checked %0d of %0d frames over %0d register settings.",
                 words_checked, frames_accepted, settings_used);
        $display("Saw %0d candidates, %0d overlong bursts, %0d confirmations, %0d gaps.",
                 cand_seen, long_seen, confirm_seen, gap_seen);
        if (err_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("%0d mismatches in total", err_count);
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

### filelist.f
design/sed_pkg.sv
design/sed_in_if.sv
design/sed_out_if.sv
design/sed_front.sv
design/sed_queue.sv
design/sed_back.sv
design/squeak_event_detector.sv
tb/sv/tb_squeak_event_detector.sv
